// ----- rtl/strip_c_comments_core_defines.svh -----
// assertion macros for the comment stripper
`ifndef STRIP_C_COMMENTS_CORE_DEFINES_SVH
`define STRIP_C_COMMENTS_CORE_DEFINES_SVH

`ifndef SYNTH
`define SCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_ASSERT_IMP(lbl, ante, cons, msg)
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/scc_pkg.sv -----
// shared types and constants of the comment stripper
package scc_pkg;

    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] BOM0 = 8'hEF;
    localparam logic [7:0] BOM1 = 8'hBB;
    localparam logic [7:0] BOM2 = 8'hBF;

    // queue depth is a power of two
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef logic [QUEUE_AW-1:0] ptr_t;
    typedef logic [QUEUE_AW:0]   count_t;

    // stripped bytes of one input word, plus end of text marking and error flag
    typedef struct packed {
        logic       b0_v;
        logic [7:0] b0;
        logic       b1_v;
        logic [7:0] b1;
        logic       last;
        logic       err;
    } cmd_t;

endpackage

// ----- rtl/scc_front.sv -----
// front end: comment scanner that turns input words into stripped-byte commands
module scc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          final_byte,
    output scc_pkg::cmd_t cmd,
    output logic          cmd_write
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    mode_t mode_after;

    always_comb
    begin
        mode_after = mode_reg;
        cmd        = '0;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == scc_pkg::CHAR_SLASH)
                begin
                    mode_after = MODE_LINE;
                end
                else if (in_byte == scc_pkg::CHAR_STAR)
                begin
                    mode_after = MODE_BLOCK;
                end
                else
                begin
                    cmd.b0_v   = 1'b1;
                    cmd.b0     = scc_pkg::CHAR_SLASH;
                    cmd.b1_v   = 1'b1;
                    cmd.b1     = in_byte;
                    mode_after = MODE_NORMAL;
                end
            end
            MODE_LINE:
            begin
                if (in_byte == scc_pkg::CHAR_NEWLINE)
                begin
                    cmd.b0_v   = 1'b1;
                    cmd.b0     = in_byte;
                    mode_after = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (in_byte == scc_pkg::CHAR_STAR)
                begin
                    mode_after = MODE_BLOCK_STAR;
                end
                else if (in_byte == scc_pkg::CHAR_NEWLINE)
                begin
                    cmd.b0_v = 1'b1;
                    cmd.b0   = in_byte;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (in_byte == scc_pkg::CHAR_SLASH)
                begin
                    mode_after = MODE_NORMAL;
                end
                else if (in_byte != scc_pkg::CHAR_STAR)
                begin
                    mode_after = MODE_BLOCK;
                    if (in_byte == scc_pkg::CHAR_NEWLINE)
                    begin
                        cmd.b0_v = 1'b1;
                        cmd.b0   = in_byte;
                    end
                end
            end
            MODE_NORMAL:
            begin
                if (in_byte == scc_pkg::CHAR_SLASH)
                begin
                    mode_after = MODE_SLASH;
                end
                else
                begin
                    cmd.b0_v = 1'b1;
                    cmd.b0   = in_byte;
                end
            end
            default:
            begin
                if (in_byte == scc_pkg::CHAR_SLASH)
                begin
                    mode_after = MODE_SLASH;
                end
                else
                begin
                    mode_after = MODE_NORMAL;
                    cmd.b0_v   = 1'b1;
                    cmd.b0     = in_byte;
                end
            end
        endcase

        mode_next = mode_after;
        if (final_byte)
        begin
            // a held slash only comes from a slash seen in normal text, so b0 is free
            if (mode_after == MODE_SLASH)
            begin
                cmd.b0_v = 1'b1;
                cmd.b0   = scc_pkg::CHAR_SLASH;
            end
            cmd.last  = 1'b1;
            cmd.err   = (mode_after == MODE_BLOCK) || (mode_after == MODE_BLOCK_STAR);
            mode_next = MODE_NORMAL;
        end

        cmd_write = accept && (cmd.b0_v || cmd.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- rtl/scc_queue.sv -----
// small command queue between scanner and output sequencer
`include "strip_c_comments_core_defines.svh"

module scc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  scc_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output scc_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    scc_pkg::cmd_t   mem_reg [scc_pkg::QUEUE_DEPTH];
    scc_pkg::ptr_t   wr_ptr_reg;
    scc_pkg::ptr_t   rd_ptr_reg;
    scc_pkg::count_t count_reg;
    scc_pkg::count_t count_next;

    assign full    = (count_reg == scc_pkg::count_t'(scc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + scc_pkg::count_t'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - scc_pkg::count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + scc_pkg::ptr_t'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + scc_pkg::ptr_t'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SCC_ASSERT_IMP(a_no_overflow, wr_en, !full, "queue written while full")
    `SCC_ASSERT_IMP(a_no_underflow, rd_en, !empty, "queue read while empty")
    `SCC_ASSERT_NEXT(a_drain_last, !wr_en && rd_en && (count_reg == scc_pkg::count_t'(1)), empty, "queue not empty after last read")

endmodule

// ----- rtl/scc_back.sv -----
// back end: byte-order-mark filter, result sequencer; one word per cycle if popped
`include "strip_c_comments_core_defines.svh"

module scc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  scc_pkg::cmd_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic          pop,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          end_of_text,
    output logic          unterminated_error
);

    typedef enum logic [1:0] {
        STEP_B0,
        STEP_B1,
        STEP_END
    } step_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_EF,
        PH_EFBB,
        PH_DONE,
        PH_BB_REPLAY
    } phase_t;

    scc_pkg::cmd_t cmd_reg;
    logic          cmd_valid_reg;
    step_t         step_reg;
    phase_t        phase_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          eot_reg;
    logic          err_reg;

    logic          advance;
    logic          work;
    logic [7:0]    cur_byte;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_bv;
    logic          emit_eot;
    logic          emit_err;
    logic          step_done;
    phase_t        phase_after;
    step_t         step_following;
    logic          step_more;
    logic          finish;

    assign advance  = !out_valid_reg || pop;
    assign work     = cmd_valid_reg && advance;
    assign cur_byte = (step_reg == STEP_B1) ? cmd_reg.b1 : cmd_reg.b0;

    always_comb
    begin
        emit        = 1'b0;
        emit_byte   = '0;
        emit_bv     = 1'b0;
        emit_eot    = 1'b0;
        emit_err    = 1'b0;
        step_done   = 1'b0;
        phase_after = phase_reg;
        if (step_reg == STEP_END)
        begin
            unique case (phase_reg)
                PH_EF:
                begin
                    emit        = 1'b1;
                    emit_byte   = scc_pkg::BOM0;
                    emit_bv     = 1'b1;
                    phase_after = PH_DONE;
                end
                PH_EFBB:
                begin
                    emit        = 1'b1;
                    emit_byte   = scc_pkg::BOM0;
                    emit_bv     = 1'b1;
                    phase_after = PH_BB_REPLAY;
                end
                PH_BB_REPLAY:
                begin
                    emit        = 1'b1;
                    emit_byte   = scc_pkg::BOM1;
                    emit_bv     = 1'b1;
                    phase_after = PH_DONE;
                end
                default:
                begin
                    // closing word, mark state cleared for the next text
                    emit        = 1'b1;
                    emit_eot    = 1'b1;
                    emit_err    = cmd_reg.err;
                    step_done   = 1'b1;
                    phase_after = PH_NONE;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_NONE:
                begin
                    step_done = 1'b1;
                    if (cur_byte == scc_pkg::BOM0)
                    begin
                        phase_after = PH_EF;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_byte   = cur_byte;
                        emit_bv     = 1'b1;
                        phase_after = PH_DONE;
                    end
                end
                PH_EF:
                begin
                    if (cur_byte == scc_pkg::BOM1)
                    begin
                        step_done   = 1'b1;
                        phase_after = PH_EFBB;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_byte   = scc_pkg::BOM0;
                        emit_bv     = 1'b1;
                        phase_after = PH_DONE;
                    end
                end
                PH_EFBB:
                begin
                    if (cur_byte == scc_pkg::BOM2)
                    begin
                        step_done   = 1'b1;
                        phase_after = PH_DONE;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_byte   = scc_pkg::BOM0;
                        emit_bv     = 1'b1;
                        phase_after = PH_BB_REPLAY;
                    end
                end
                PH_BB_REPLAY:
                begin
                    emit        = 1'b1;
                    emit_byte   = scc_pkg::BOM1;
                    emit_bv     = 1'b1;
                    phase_after = PH_DONE;
                end
                default:
                begin
                    emit      = 1'b1;
                    emit_byte = cur_byte;
                    emit_bv   = 1'b1;
                    step_done = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        step_following = STEP_END;
        step_more      = 1'b0;
        unique case (step_reg)
            STEP_B0:
            begin
                if (cmd_reg.b1_v)
                begin
                    step_following = STEP_B1;
                    step_more      = 1'b1;
                end
                else
                begin
                    step_more = cmd_reg.last;
                end
            end
            STEP_B1:
            begin
                step_more = cmd_reg.last;
            end
            default:
            begin
                step_more = 1'b0;
            end
        endcase
    end

    assign finish = work && step_done && !step_more;
    assign q_pop  = !q_empty && (!cmd_valid_reg || finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            step_reg       <= STEP_B0;
            phase_reg      <= PH_NONE;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            eot_reg        <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (work)
            begin
                phase_reg <= phase_after;
            end
            if (q_pop)
            begin
                cmd_valid_reg <= 1'b1;
                cmd_reg       <= q_data;
                step_reg      <= q_data.b0_v ? STEP_B0 : STEP_END;
            end
            else if (finish)
            begin
                cmd_valid_reg <= 1'b0;
            end
            else if (work && step_done)
            begin
                step_reg <= step_following;
            end
            if (advance)
            begin
                out_valid_reg  <= work && emit;
                out_byte_reg   <= emit_byte;
                byte_valid_reg <= emit_bv;
                eot_reg        <= emit_eot;
                err_reg        <= emit_err;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_byte           = out_byte_reg;
    assign byte_valid         = byte_valid_reg;
    assign end_of_text        = eot_reg;
    assign unterminated_error = err_reg;

    `SCC_ASSERT_IMP(a_closing_shape, out_valid_reg && !byte_valid_reg, eot_reg && (out_byte_reg == 8'h00), "result word is neither byte nor closing")
    `SCC_ASSERT_IMP(a_err_on_close, out_valid_reg && err_reg, eot_reg && !byte_valid_reg, "error flag on a text byte")
    `SCC_ASSERT_NEXT(a_mark_cleared, work && emit && emit_eot, phase_reg == PH_NONE, "mark phase not cleared after closing word")

endmodule

// ----- rtl/strip_c_comments_core.sv -----
// top level of the comment stripper: scanner, command queue, output sequencer
//
//  channel  | handshake        | words
//  ---------+------------------+----------------------------------------------
//  input    | push / full      | in_byte, final_byte
//  result   | empty / pop      | out_byte, byte_valid, end_of_text,
//           |                  | unterminated_error
//
// the scanner takes one input word per cycle while the command queue has room
// the sequencer handles one result word or absorbed byte per step, so a held
// slash, a replayed mark or a closing word adds a step to that input word
// results come from an output register; a word can be accepted while one waits
// reset clears scanner mode, queue, mark phase and output register at once
`include "strip_c_comments_core_defines.svh"

module strip_c_comments_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_text,
    output logic       unterminated_error
);

    scc_pkg::cmd_t front_cmd;
    scc_pkg::cmd_t q_data;
    logic          accept;
    logic          cmd_write;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          out_valid;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    scc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .cmd        (front_cmd),
        .cmd_write  (cmd_write)
    );

    scc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_write),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    scc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_data             (q_data),
        .q_empty            (q_empty),
        .q_pop              (q_pop),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_byte           (out_byte),
        .byte_valid         (byte_valid),
        .end_of_text        (end_of_text),
        .unterminated_error (unterminated_error)
    );

    `SCC_ASSERT_IMP(a_write_needs_accept, cmd_write, accept, "command written without an accepted word")

endmodule

// ----- tb/sv/comment_strip_checker.sv -----
// checker for the comment stripper: predicts stripped words and compares results
module comment_strip_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       end_of_text,
    input  logic       unterminated_error,
    output int         pending,
    output int         fail_count
);

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BLOCK_STAR
    } scan_mode_t;

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_EF,
        MARK_EF_BB,
        MARK_DONE
    } mark_phase_t;

    typedef struct packed {
        logic [7:0] text;
        logic       valid;
        logic       eot;
        logic       err;
    } text_word_t;

    scan_mode_t  scan;
    mark_phase_t mark_phase;
    text_word_t  stripped_words[$];
    text_word_t  seen;
    text_word_t  want;

    initial
    begin
        pending    = 0;
        fail_count = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    function automatic void put_text(input logic [7:0] b);
        stripped_words.insert(stripped_words.size(), '{b, 1'b1, 1'b0, 1'b0});
    endfunction

    // byte order mark filter on the stripped stream
    function automatic void pass_mark(input logic [7:0] b);
        case (mark_phase)
            MARK_NONE:
            begin
                if (b == scc_pkg::BOM0)
                    mark_phase = MARK_EF;
                else
                begin
                    mark_phase = MARK_DONE;
                    put_text(b);
                end
            end
            MARK_EF:
            begin
                if (b == scc_pkg::BOM1)
                    mark_phase = MARK_EF_BB;
                else
                begin
                    mark_phase = MARK_DONE;
                    put_text(scc_pkg::BOM0);
                    put_text(b);
                end
            end
            MARK_EF_BB:
            begin
                mark_phase = MARK_DONE;
                if (b != scc_pkg::BOM2)
                begin
                    put_text(scc_pkg::BOM0);
                    put_text(scc_pkg::BOM1);
                    put_text(b);
                end
            end
            default:
                put_text(b);
        endcase
    endfunction

    function automatic void scan_plain(input logic [7:0] c);
        if (c == scc_pkg::CHAR_SLASH)
            scan = SCAN_SLASH;
        else
        begin
            scan = SCAN_NORMAL;
            pass_mark(c);
        end
    endfunction

    function automatic void strip_word(input logic [7:0] c, input logic last);
        logic err;
        case (scan)
            SCAN_SLASH:
            begin
                if (c == scc_pkg::CHAR_SLASH)
                    scan = SCAN_LINE;
                else if (c == scc_pkg::CHAR_STAR)
                    scan = SCAN_BLOCK;
                else
                begin
                    pass_mark(scc_pkg::CHAR_SLASH);
                    scan_plain(c);
                end
            end
            SCAN_LINE:
            begin
                if (c == scc_pkg::CHAR_NEWLINE)
                begin
                    pass_mark(c);
                    scan = SCAN_NORMAL;
                end
            end
            SCAN_BLOCK:
            begin
                if (c == scc_pkg::CHAR_STAR)
                    scan = SCAN_BLOCK_STAR;
                else if (c == scc_pkg::CHAR_NEWLINE)
                    pass_mark(c);
            end
            SCAN_BLOCK_STAR:
            begin
                if (c == scc_pkg::CHAR_SLASH)
                    scan = SCAN_NORMAL;
                else if (c != scc_pkg::CHAR_STAR)
                begin
                    scan = SCAN_BLOCK;
                    if (c == scc_pkg::CHAR_NEWLINE)
                        pass_mark(c);
                end
            end
            default:
                scan_plain(c);
        endcase
        if (last)
        begin
            if (scan == SCAN_SLASH)
                pass_mark(scc_pkg::CHAR_SLASH);
            err = (scan == SCAN_BLOCK) || (scan == SCAN_BLOCK_STAR);
            if (mark_phase == MARK_EF)
                put_text(scc_pkg::BOM0);
            else if (mark_phase == MARK_EF_BB)
            begin
                put_text(scc_pkg::BOM0);
                put_text(scc_pkg::BOM1);
            end
            stripped_words.insert(stripped_words.size(), '{8'h00, 1'b0, 1'b1, err});
            scan       = SCAN_NORMAL;
            mark_phase = MARK_NONE;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan       = SCAN_NORMAL;
            mark_phase = MARK_NONE;
            stripped_words.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                seen = '{out_byte, byte_valid, end_of_text, unterminated_error};
                if (stripped_words.size() == 0)
                    report_mismatch("unexpected word", seen, 0);
                else
                begin
                    want = stripped_words.pop_front();
                    if (seen.text !== want.text)
                        report_mismatch("out_byte", seen.text, want.text);
                    if (seen.valid !== want.valid)
                        report_mismatch("byte_valid", seen.valid, want.valid);
                    if (seen.eot !== want.eot)
                        report_mismatch("end_of_text", seen.eot, want.eot);
                    if (seen.err !== want.err)
                        report_mismatch("unterminated_error", seen.err, want.err);
                end
            end
            if (push && !full)
                strip_word(in_byte, final_byte);
            pending <= stripped_words.size();
        end
    end

endmodule

// ----- tb/sv/strip_c_comments_core_tb.sv -----
// testbench top for the comment stripper: stimulus, idling, watchdog and verdict
module strip_c_comments_core_tb;

    typedef logic [7:0] text_q_t[$];

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_WORDS = 25;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic       unterminated_error;

    int pending;
    int fail_count;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int sent_words = 0;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    strip_c_comments_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .in_byte            (in_byte),
        .final_byte         (final_byte),
        .empty              (empty),
        .pop                (pop),
        .out_byte           (out_byte),
        .byte_valid         (byte_valid),
        .end_of_text        (end_of_text),
        .unterminated_error (unterminated_error)
    );

    comment_strip_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .in_byte            (in_byte),
        .final_byte         (final_byte),
        .empty              (empty),
        .pop                (pop),
        .out_byte           (out_byte),
        .byte_valid         (byte_valid),
        .end_of_text        (end_of_text),
        .unterminated_error (unterminated_error),
        .pending            (pending),
        .fail_count         (fail_count)
    );

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAIL strip_c_comments_core");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        // sender idles cycle by cycle
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        in_byte    <= b;
        final_byte <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_words++;
    endtask

    task automatic send_text(input text_q_t t);
        foreach (t[i])
            send_word(t[i], i == t.size() - 1);
    endtask

    task automatic send_random_text();
        text_q_t t;
        int      len;
        int      pick;
        len = ($urandom_range(7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        // leading byte order mark, whole or partial
        if ($urandom_range(3) == 0)
        begin
            t.insert(t.size(), scc_pkg::BOM0);
            if ($urandom_range(3) != 0)
            begin
                t.insert(t.size(), scc_pkg::BOM1);
                if ($urandom_range(3) != 0)
                    t.insert(t.size(), scc_pkg::BOM2);
            end
        end
        while (t.size() < len)
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1:    t.insert(t.size(), scc_pkg::CHAR_SLASH);
                2, 3:    t.insert(t.size(), scc_pkg::CHAR_STAR);
                4:       t.insert(t.size(), scc_pkg::CHAR_NEWLINE);
                5:       t.insert(t.size(), ($urandom_range(2) == 0) ? scc_pkg::BOM0 :
                                   ($urandom_range(1) == 0) ? scc_pkg::BOM1 : scc_pkg::BOM2);
                default: t.insert(t.size(), 8'($urandom_range(255)));
            endcase
        end
        send_text(t);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text('{scc_pkg::BOM0, scc_pkg::BOM1, scc_pkg::BOM2, 8'h41});
        send_text('{scc_pkg::BOM0});
        send_text('{scc_pkg::BOM0, scc_pkg::BOM1});
        send_text('{scc_pkg::CHAR_SLASH, scc_pkg::CHAR_STAR, scc_pkg::CHAR_NEWLINE,
                    scc_pkg::CHAR_STAR, scc_pkg::CHAR_STAR, scc_pkg::CHAR_SLASH,
                    8'hFF, scc_pkg::CHAR_SLASH, 8'h41, scc_pkg::CHAR_SLASH});
        send_text('{scc_pkg::CHAR_SLASH, scc_pkg::CHAR_SLASH, 8'h00, scc_pkg::CHAR_NEWLINE,
                    scc_pkg::CHAR_SLASH, scc_pkg::CHAR_STAR, 8'h58});
        send_text('{scc_pkg::CHAR_SLASH, scc_pkg::CHAR_SLASH, 8'h41});

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 47;
                end
                default:
                begin
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            sent_words = 0;
            while (sent_words < PHASE_WORDS)
                send_random_text();
        end

        // long receiver hold-off while the sender keeps offering words
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 80;
        sent_words    = 0;
        while (sent_words < 20)
            send_random_text();

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS strip_c_comments_core");
        else
            $display("FAIL strip_c_comments_core");
        $finish;
    end

endmodule
